FILE: rtl/stgb_pkg.sv
// ----------------------------------------------------------------------------
// State transition graph builder package
// Shared request types, key layout constants and default sizes.
// ----------------------------------------------------------------------------
package stgb_pkg;

  localparam int DEF_FIGHTERS  = 2;
  localparam int DEF_MAX_NODES = 256;
  localparam int DEF_MAX_EDGES = 1024;

  localparam logic [15:0] GUARD_DAMAGE = 16'd30;
  localparam logic [15:0] WEIGHT_MAX   = 16'hFFFF;
  localparam int          QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic [2:0]  fighter;
    logic        two_fighters;
    logic [39:0] motion;
    logic [15:0] status;
    logic [7:0]  hit_status;
    logic [15:0] hitstun;
    logic [15:0] prev_hitstun;
    logic        attack_connected;
    logic [15:0] opp_hitstun;
    logic [15:0] opp_prev_hitstun;
    logic [15:0] opp_status;
    logic        opp_attack_connected;
  } in_t;

  typedef struct packed {
    logic [2:0]  out_fighter;
    logic        skipped;
    logic [7:0]  node_index;
    logic        new_node;
    logic        has_edge;
    logic [9:0]  edge_index;
    logic        new_edge;
    logic [15:0] edge_weight;
    logic        table_full;
  } out_t;

  typedef struct packed {
    logic [2:0]  fighter;
    logic        skip;
    logic [39:0] motion;
    logic [29:0] rest;
  } work_t;

endpackage

FILE: rtl/stgb_front.sv
// ----------------------------------------------------------------------------
// State transition graph builder front end
// Forms the state key, marks repeats of each fighter's last key as skipped and queues work.
// ----------------------------------------------------------------------------
module stgb_front #(
  parameter int FIGHTERS = stgb_pkg::DEF_FIGHTERS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  stgb_pkg::in_t  in_data,
  input  logic           q_full,
  output logic           q_push,
  output stgb_pkg::work_t q_data
);
  import stgb_pkg::*;

  localparam int FW = (FIGHTERS > 1) ? $clog2(FIGHTERS) : 1;
  localparam int FN = 2 ** FW;

  logic        last_valid_r [FN];
  logic [39:0] last_motion_r [FN];
  logic [29:0] last_rest_r [FN];
  logic [FW-1:0] fsel;
  logic        in_range;
  logic        repeat_key;
  logic [29:0] rest;
  logic        accept;

  assign fsel     = in_data.fighter[FW-1:0];
  assign in_range = ({29'd0, in_data.fighter} < FIGHTERS);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    rest = {6'd0, in_data.hit_status, in_data.status};
    rest[24] = in_data.two_fighters && in_data.opp_attack_connected &&
               (in_data.hitstun == in_data.prev_hitstun);
    rest[25] = (in_data.hitstun != 16'd0);
    rest[26] = (in_data.status == GUARD_DAMAGE);
    rest[27] = in_data.two_fighters && in_data.attack_connected &&
               (in_data.opp_hitstun == in_data.opp_prev_hitstun);
    rest[28] = in_data.two_fighters && (in_data.opp_hitstun != 16'd0);
    rest[29] = in_data.two_fighters && (in_data.opp_status == GUARD_DAMAGE);
  end

  assign repeat_key = last_valid_r[fsel] && (last_motion_r[fsel] == in_data.motion) &&
                      (last_rest_r[fsel] == rest);

  assign q_push         = accept;
  assign q_data.fighter = in_data.fighter;
  assign q_data.skip    = !in_range || repeat_key;
  assign q_data.motion  = in_data.motion;
  assign q_data.rest    = rest;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FN; i++) begin
        last_valid_r[i]  <= 1'b0;
        last_motion_r[i] <= '0;
        last_rest_r[i]   <= '0;
      end
    end else if (accept && in_range && !repeat_key) begin
      last_valid_r[fsel]  <= 1'b1;
      last_motion_r[fsel] <= in_data.motion;
      last_rest_r[fsel]   <= rest;
    end
  end

endmodule

FILE: rtl/stgb_queue.sv
// ----------------------------------------------------------------------------
// State transition graph builder work queue
// A short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module stgb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stgb_pkg::work_t push_data,
  input  logic            pop,
  output stgb_pkg::work_t pop_data,
  output logic            full,
  output logic            empty
);
  import stgb_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  work_t          buf_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_r;
  logic [PW-1:0]  rd_r;
  logic [PW:0]    cnt_r;

  assign full     = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      buf_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

endmodule

FILE: rtl/stgb_back.sv
// ----------------------------------------------------------------------------
// State transition graph builder back end
// Searches and extends the node and edge tables one entry per step.
// ----------------------------------------------------------------------------
module stgb_back #(
  parameter int FIGHTERS  = stgb_pkg::DEF_FIGHTERS,
  parameter int MAX_NODES = stgb_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = stgb_pkg::DEF_MAX_EDGES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  stgb_pkg::work_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output stgb_pkg::out_t  out_data
);
  import stgb_pkg::*;

  localparam int FW  = (FIGHTERS > 1) ? $clog2(FIGHTERS) : 1;
  localparam int FN  = 2 ** FW;
  localparam int NIW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EIW = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EDW = 2 * NIW + 16;

  typedef enum logic [2:0] {
    S_IDLE, S_NCHK, S_NCMP, S_EDGE, S_ECHK, S_ECMP
  } state_t;

  state_t         state_r;
  work_t          ent_r;
  logic [NCW-1:0] idx_r;
  logic [ECW-1:0] eidx_r;
  logic [NIW-1:0] node_r;
  logic           nnew_r;
  logic [NCW-1:0] node_cnt_r [FN];
  logic [ECW-1:0] edge_cnt_r [FN];
  logic           prev_v_r [FN];
  logic [NIW-1:0] prev_r [FN];
  out_t           out_r;
  logic           out_valid_r;

  logic [69:0]    nmem [FN * (2 ** NIW)];
  logic [EDW-1:0] emem [FN * (2 ** EIW)];
  logic [69:0]    nq_r;
  logic [EDW-1:0] eq_r;

  logic [FW-1:0]      fsel;
  logic [FW+NIW-1:0]  naddr;
  logic [FW+EIW-1:0]  eaddr;
  logic [NCW-1:0]     ncnt;
  logic [ECW-1:0]     ecnt;
  logic               nwe;
  logic               ewe;
  logic               pair_hit;
  logic [15:0]        wsat;
  logic [EDW-1:0]     ewdata;
  logic [NIW+7:0]     node_ext;
  logic [ECW+9:0]     edge_ext;

  assign fsel     = ent_r.fighter[FW-1:0];
  assign naddr    = {fsel, idx_r[NIW-1:0]};
  assign eaddr    = {fsel, eidx_r[EIW-1:0]};
  assign ncnt     = node_cnt_r[fsel];
  assign ecnt     = edge_cnt_r[fsel];
  assign pair_hit = (eq_r[EDW-1:16] == {prev_r[fsel], node_r});
  assign wsat     = (eq_r[15:0] == WEIGHT_MAX) ? eq_r[15:0] : eq_r[15:0] + 16'd1;
  assign node_ext = {8'd0, node_r};
  assign edge_ext = {10'd0, eidx_r};
  assign q_pop    = (state_r == S_IDLE) && !q_empty && !out_valid_r;

  assign nwe = (state_r == S_NCHK) && (idx_r == ncnt) && (ncnt < NCW'(MAX_NODES));

  always_comb begin
    ewe    = 1'b0;
    ewdata = {prev_r[fsel], node_r, 16'd1};
    if ((state_r == S_ECHK) && (eidx_r == ecnt) && (ecnt < ECW'(MAX_EDGES))) begin
      ewe = 1'b1;
    end else if ((state_r == S_ECMP) && pair_hit) begin
      ewe    = 1'b1;
      ewdata = {eq_r[EDW-1:16], wsat};
    end
  end

  always_ff @(posedge clk) begin
    if (nwe) begin
      nmem[naddr] <= {ent_r.motion, ent_r.rest};
    end
    nq_r <= nmem[naddr];
  end

  always_ff @(posedge clk) begin
    if (ewe) begin
      emem[eaddr] <= ewdata;
    end
    eq_r <= emem[eaddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FN; i++) begin
        node_cnt_r[i] <= '0;
        edge_cnt_r[i] <= '0;
        prev_v_r[i]   <= 1'b0;
        prev_r[i]     <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            ent_r  <= q_data;
            idx_r  <= '0;
            eidx_r <= '0;
            nnew_r <= 1'b0;
            if (q_data.skip) begin
              out_r             <= '0;
              out_r.out_fighter <= q_data.fighter;
              out_r.skipped     <= 1'b1;
              out_valid_r       <= 1'b1;
            end else begin
              state_r <= S_NCHK;
            end
          end
        end
        S_NCHK: begin
          if (idx_r != ncnt) begin
            state_r <= S_NCMP;
          end else if (nwe) begin
            node_r           <= idx_r[NIW-1:0];
            nnew_r           <= 1'b1;
            node_cnt_r[fsel] <= ncnt + 1'b1;
            state_r          <= S_EDGE;
          end else begin
            out_r             <= '0;
            out_r.out_fighter <= ent_r.fighter;
            out_r.table_full  <= 1'b1;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        S_NCMP: begin
          if (nq_r == {ent_r.motion, ent_r.rest}) begin
            node_r  <= idx_r[NIW-1:0];
            state_r <= S_EDGE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_NCHK;
          end
        end
        S_EDGE: begin
          if (prev_v_r[fsel]) begin
            state_r <= S_ECHK;
          end else begin
            out_r             <= '0;
            out_r.out_fighter <= ent_r.fighter;
            out_r.node_index  <= node_ext[7:0];
            out_r.new_node    <= nnew_r;
            out_valid_r       <= 1'b1;
            prev_v_r[fsel]    <= 1'b1;
            prev_r[fsel]      <= node_r;
            state_r           <= S_IDLE;
          end
        end
        S_ECHK: begin
          if (eidx_r != ecnt) begin
            state_r <= S_ECMP;
          end else begin
            out_r             <= '0;
            out_r.out_fighter <= ent_r.fighter;
            out_r.node_index  <= node_ext[7:0];
            out_r.new_node    <= nnew_r;
            if (ewe) begin
              out_r.has_edge    <= 1'b1;
              out_r.edge_index  <= edge_ext[9:0];
              out_r.new_edge    <= 1'b1;
              out_r.edge_weight <= 16'd1;
              edge_cnt_r[fsel]  <= ecnt + 1'b1;
            end else begin
              out_r.table_full <= 1'b1;
            end
            out_valid_r    <= 1'b1;
            prev_r[fsel]   <= node_r;
            state_r        <= S_IDLE;
          end
        end
        S_ECMP: begin
          if (pair_hit) begin
            out_r             <= '0;
            out_r.out_fighter <= ent_r.fighter;
            out_r.node_index  <= node_ext[7:0];
            out_r.new_node    <= nnew_r;
            out_r.has_edge    <= 1'b1;
            out_r.edge_index  <= edge_ext[9:0];
            out_r.edge_weight <= wsat;
            out_valid_r       <= 1'b1;
            prev_r[fsel]      <= node_r;
            state_r           <= S_IDLE;
          end else begin
            eidx_r  <= eidx_r + 1'b1;
            state_r <= S_ECHK;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_weight_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.has_edge |-> out_r.edge_weight != 16'd0)
    else $error("edge result with zero weight");

  a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.skipped |-> !out_r.table_full && !out_r.new_node && !out_r.has_edge)
    else $error("skipped result carries table fields");

  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> ncnt <= NCW'(MAX_NODES))
    else $error("node count beyond table size");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE && !out_valid_r)
    else $error("request taken while result pending");

endmodule

FILE: rtl/state_transition_graph_builder.sv
// ----------------------------------------------------------------------------
// State transition graph builder
// Builds per-fighter node and edge tables from frame samples.
// ----------------------------------------------------------------------------
// Each request yields exactly one result. The front end queues each request
// as it is taken; the back end then walks the fighter's node table and edge
// table one entry at a time through single-port memories. Tables start empty
// after reset with no clearing pass.
module state_transition_graph_builder #(
  parameter int FIGHTERS  = stgb_pkg::DEF_FIGHTERS,
  parameter int MAX_NODES = stgb_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = stgb_pkg::DEF_MAX_EDGES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  stgb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output stgb_pkg::out_t out_data
);
  import stgb_pkg::*;

  work_t push_data;
  work_t pop_data;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  stgb_front #(.FIGHTERS(FIGHTERS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (full),
    .q_push  (push),
    .q_data  (push_data)
  );

  stgb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (full),
    .empty    (empty)
  );

  stgb_back #(
    .FIGHTERS (FIGHTERS),
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the state transition graph builder
// A short table of requests is run first. Some rows carry typed-in results and
// the others are checked against a state predictor. Random requests follow,
// drawn from a small pool of keys per fighter. Two long phases then fill a
// node table and an edge table. Handshakes idle at random but for a quiet span.
// ----------------------------------------------------------------------------
module tb_top;
  import stgb_pkg::*;

  localparam int NF  = DEF_FIGHTERS;
  localparam int NN  = DEF_MAX_NODES;
  localparam int NE  = DEF_MAX_EDGES;
  localparam int INW = $bits(in_t);

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  state_transition_graph_builder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Per-fighter graph state.
  logic        last_ok [NF];
  logic [69:0] last_key [NF];
  logic        prev_ok [NF];
  logic [7:0]  prev_idx [NF];
  int          node_cnt [NF];
  logic [69:0] node_key [NF][NN];
  int          edge_cnt [NF];
  logic [7:0]  edge_src [NF][NE];
  logic [7:0]  edge_dst [NF][NE];
  logic [15:0] edge_wt [NF][NE];
  int          full_seen [NF];

  out_t expected_q[$];
  out_t typed_q[$];
  logic typed_on[$];
  int   errors = 0;
  logic quiet = 1'b0;

  function automatic out_t graph_step(in_t d);
    out_t r;
    logic [29:0] rest;
    logic [69:0] key;
    int f;
    int node;
    int e;
    logic found;
    r = '0;
    r.out_fighter = d.fighter;
    r.skipped = 1'b1;
    f = d.fighter;
    if (f >= NF) return r;
    rest = {6'd0, d.hit_status, d.status};
    rest[24] = d.two_fighters & d.opp_attack_connected & (d.hitstun == d.prev_hitstun);
    rest[25] = d.hitstun != 0;
    rest[26] = d.status == GUARD_DAMAGE;
    rest[27] = d.two_fighters & d.attack_connected & (d.opp_hitstun == d.opp_prev_hitstun);
    rest[28] = d.two_fighters & (d.opp_hitstun != 0);
    rest[29] = d.two_fighters & (d.opp_status == GUARD_DAMAGE);
    key = {d.motion, rest};
    if (last_ok[f] && last_key[f] == key) return r;
    r.skipped = 1'b0;
    last_ok[f] = 1'b1;
    last_key[f] = key;
    found = 1'b0;
    node = 0;
    for (int i = 0; i < node_cnt[f]; i++) begin
      if (!found && node_key[f][i] == key) begin
        found = 1'b1;
        node = i;
      end
    end
    if (!found) begin
      if (node_cnt[f] >= NN) begin
        r.table_full = 1'b1;
        full_seen[f]++;
        return r;
      end
      node = node_cnt[f];
      node_key[f][node] = key;
      node_cnt[f]++;
      r.new_node = 1'b1;
    end
    r.node_index = node[7:0];
    if (prev_ok[f]) begin
      found = 1'b0;
      e = 0;
      for (int i = 0; i < edge_cnt[f]; i++) begin
        if (!found && edge_src[f][i] == prev_idx[f] && edge_dst[f][i] == node[7:0]) begin
          found = 1'b1;
          e = i;
        end
      end
      if (found) begin
        if (edge_wt[f][e] != WEIGHT_MAX) edge_wt[f][e]++;
        r.has_edge = 1'b1;
        r.edge_index = e[9:0];
        r.edge_weight = edge_wt[f][e];
      end else if (edge_cnt[f] >= NE) begin
        r.table_full = 1'b1;
        full_seen[f]++;
      end else begin
        e = edge_cnt[f];
        edge_src[f][e] = prev_idx[f];
        edge_dst[f][e] = node[7:0];
        edge_wt[f][e] = 16'd1;
        edge_cnt[f]++;
        r.has_edge = 1'b1;
        r.edge_index = e[9:0];
        r.new_edge = 1'b1;
        r.edge_weight = 16'd1;
      end
    end
    prev_ok[f] = 1'b1;
    prev_idx[f] = node[7:0];
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    out_t pred;
    if (rst_n && in_valid && !in_stall) begin
      pred = graph_step(in_data);
      if (typed_on.size() != 0 && typed_on.pop_front()) pred = typed_q.pop_front();
      expected_q.push_back(pred);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected result, fighter", out_data.out_fighter, -1);
      end else begin
        want = expected_q.pop_front();
        if (out_data.out_fighter != want.out_fighter)
          report("out_fighter", out_data.out_fighter, want.out_fighter);
        if (out_data.skipped != want.skipped)
          report("skipped", out_data.skipped, want.skipped);
        if (out_data.node_index != want.node_index)
          report("node_index", out_data.node_index, want.node_index);
        if (out_data.new_node != want.new_node)
          report("new_node", out_data.new_node, want.new_node);
        if (out_data.has_edge != want.has_edge)
          report("has_edge", out_data.has_edge, want.has_edge);
        if (out_data.edge_index != want.edge_index)
          report("edge_index", out_data.edge_index, want.edge_index);
        if (out_data.new_edge != want.new_edge)
          report("new_edge", out_data.new_edge, want.new_edge);
        if (out_data.edge_weight != want.edge_weight)
          report("edge_weight", out_data.edge_weight, want.edge_weight);
        if (out_data.table_full != want.table_full)
          report("table_full", out_data.table_full, want.table_full);
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 33);
  end

  task automatic send(in_t d, logic has_typed, out_t typed);
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    typed_on.push_back(has_typed);
    if (has_typed) typed_q.push_back(typed);
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic in_t plain_request(int f, logic [39:0] m, logic [15:0] st);
    in_t d;
    d = '0;
    d.fighter = f[2:0];
    d.motion = m;
    d.status = st;
    return d;
  endfunction

  function automatic out_t result_of(int f, logic sk, int node, logic nn, logic he,
                                     int e, logic ne, int w, logic full);
    out_t r;
    r.out_fighter = f[2:0];
    r.skipped = sk;
    r.node_index = node[7:0];
    r.new_node = nn;
    r.has_edge = he;
    r.edge_index = e[9:0];
    r.new_edge = ne;
    r.edge_weight = w[15:0];
    r.table_full = full;
    return r;
  endfunction

  typedef struct {
    in_t  req;
    logic typed;
    out_t res;
  } row_t;

  row_t        rows[$];
  row_t        row;
  logic [39:0] motion_pool [NF][3];
  logic [15:0] status_pool [NF];
  logic [7:0]  hit_pool [NF][2];
  in_t         d;
  int          f;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    for (int i = 0; i < NF; i++) begin
      last_ok[i] = 1'b0;
      last_key[i] = '0;
      prev_ok[i] = 1'b0;
      prev_idx[i] = '0;
      node_cnt[i] = 0;
      edge_cnt[i] = 0;
      full_seen[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests.
    row.typed = 1'b1;
    row.req = plain_request(0, 40'h12345, 16'd5);
    row.res = result_of(0, 0, 0, 1, 0, 0, 0, 0, 0);
    rows.push_back(row);
    row.res = result_of(0, 1, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    row.req = plain_request(7, 40'hFF_FFFF_FFFF, 16'hFFFF);
    row.res = result_of(7, 1, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    row.req = plain_request(2, 40'h1, 16'd30);
    row.res = result_of(2, 1, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    row.req = plain_request(0, 40'hFF_FFFF_FFFF, 16'd30);
    row.res = result_of(0, 0, 1, 1, 1, 0, 1, 1, 0);
    rows.push_back(row);
    row.req = plain_request(0, 40'h12345, 16'd5);
    row.res = result_of(0, 0, 0, 0, 1, 1, 1, 1, 0);
    rows.push_back(row);
    row.req = plain_request(0, 40'hFF_FFFF_FFFF, 16'd30);
    row.res = result_of(0, 0, 1, 0, 1, 0, 0, 2, 0);
    rows.push_back(row);
    row.req = plain_request(1, 40'h0, 16'h0);
    row.res = result_of(1, 0, 0, 1, 0, 0, 0, 0, 0);
    rows.push_back(row);
    row.typed = 1'b0;
    row.req = '1;
    row.req.fighter = 3'd1;
    rows.push_back(row);
    row.req.two_fighters = 1'b0;
    rows.push_back(row);
    row.req = plain_request(1, 40'h0, 16'hFFFF);
    row.req.hit_status = 8'hFF;
    row.req.hitstun = 16'h8000;
    row.req.prev_hitstun = 16'h8000;
    row.req.two_fighters = 1'b1;
    row.req.opp_attack_connected = 1'b1;
    rows.push_back(row);
    row.req.opp_status = 16'd30;
    row.req.opp_hitstun = 16'd1;
    row.req.opp_prev_hitstun = 16'd1;
    row.req.attack_connected = 1'b1;
    rows.push_back(row);
    row.req.opp_prev_hitstun = 16'd2;
    row.req.prev_hitstun = 16'd0;
    rows.push_back(row);
    row.req.two_fighters = 1'b0;
    rows.push_back(row);
    row.req = plain_request(1, 40'h0, 16'h0);
    rows.push_back(row);
    row.req = plain_request(0, 40'h12345, 16'd5);
    rows.push_back(row);
    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].res);

    // Random requests over a small pool of keys per fighter.
    for (int i = 0; i < NF; i++) begin
      status_pool[i] = 16'($urandom());
      hit_pool[i][0] = 8'($urandom());
      hit_pool[i][1] = 8'($urandom());
      for (int j = 0; j < 3; j++) motion_pool[i][j] = 40'({$urandom(), $urandom()});
    end
    for (int n = 0; n < 650; n++) begin
      quiet = (n >= 200 && n < 400);
      d = INW'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      if ($urandom_range(99) >= 4) begin
        f = ($urandom_range(99) < 8) ? $urandom_range(7, 2) : $urandom_range(1);
        d.fighter = f[2:0];
        if (f < NF) begin
          d.motion = motion_pool[f][$urandom_range(2)];
          d.status = $urandom_range(1) ? GUARD_DAMAGE : status_pool[f];
          d.hit_status = hit_pool[f][$urandom_range(1)];
        end
        if ($urandom_range(1)) d.hitstun = '0;
        if ($urandom_range(1)) d.prev_hitstun = d.hitstun;
        d.two_fighters = ($urandom_range(99) < 25);
        if (!d.two_fighters) begin
          d.attack_connected = 1'b0;
          d.opp_attack_connected = 1'b0;
        end else begin
          if ($urandom_range(1)) d.opp_hitstun = '0;
          if ($urandom_range(1)) d.opp_prev_hitstun = d.opp_hitstun;
          if ($urandom_range(1)) d.opp_status = GUARD_DAMAGE;
        end
      end
      send(d, 1'b0, '0);
    end
    quiet = 1'b0;

    // Node table fill on fighter 0.
    for (int j = 0; j < NN + 6; j++) send(plain_request(0, 40'h5000 + j, 16'd2), 1'b0, '0);
    send(plain_request(0, 40'h5000, 16'd2), 1'b0, '0);

    // Edge table fill on fighter 1: walk 37 keys stride by stride until six table_full results.
    for (int s = 1; s < 37 && full_seen[1] < 6; s++) begin
      for (int j = 0; j < 37 && full_seen[1] < 6; j++)
        send(plain_request(1, 40'h9000 + (j * s) % 37, 16'd3), 1'b0, '0);
    end
    in_valid <= 1'b0;

    for (int n = 0; n < 4000000 && expected_q.size() != 0; n++) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #1500000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: state_transition_graph_builder.f
rtl/stgb_pkg.sv
rtl/stgb_front.sv
rtl/stgb_queue.sv
rtl/stgb_back.sv
rtl/state_transition_graph_builder.sv
tb/tb_top.sv
